[rtl/iq_capture_statistics_core_defines.svh]
// Assertion helpers for the IQ capture statistics core.
// Both macros expect clk_i and rst_ni in scope.
`ifndef IQ_CAPTURE_STATISTICS_CORE_DEFINES_SVH
`define IQ_CAPTURE_STATISTICS_CORE_DEFINES_SVH

// Same-cycle implication
`define IQCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define IQCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/iqcs_pkg.sv]
`default_nettype none

package iqcs_pkg;

  // Field widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned RAW_W    = 2 * SAMPLE_W;
  localparam int unsigned CFG_W    = 13;
  localparam int unsigned AVG_W    = 20;

  // Default capture depth limit and capture_length reset value
  localparam int unsigned    MAX_SAMPLES_DEF = 4096;
  localparam logic [CFG_W-1:0] CFG_RESET     = 13'd4096;

  // Min/max tracker start values
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 10'sh1FF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 10'sh200;

  // Controller to datapath commands
  typedef struct packed {
    logic accept;    // take one sample into the accumulators
    logic start;     // capture ends: load dividers, clear accumulators
    logic step;      // one divider iteration
    logic load_out;  // copy results into the output register
  } iqcs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic cap_done;  // next accepted sample closes the capture
  } iqcs_stat_t;

endpackage

`default_nettype wire

[rtl/iqcs_if.sv]
`default_nettype none

// Sample channel
interface iqcs_samp_if;
  import iqcs_pkg::*;
  logic             valid;
  logic             ready;
  logic [RAW_W-1:0] raw_word;
  modport source (output valid, output raw_word, input ready);
  modport sink   (input valid, input raw_word, output ready);
endinterface

// Summary channel
interface iqcs_summ_if;
  import iqcs_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean_i;
  logic signed [SAMPLE_W-1:0] mean_q;
  logic signed [SAMPLE_W-1:0] min_i_out;
  logic signed [SAMPLE_W-1:0] max_i_out;
  logic signed [SAMPLE_W-1:0] min_q_out;
  logic signed [SAMPLE_W-1:0] max_q_out;
  logic [AVG_W-1:0]           mean_power;
  modport source (output valid, output mean_i, output mean_q, output min_i_out,
                  output max_i_out, output min_q_out, output max_q_out,
                  output mean_power, input ready);
  modport sink   (input valid, input mean_i, input mean_q, input min_i_out,
                  input max_i_out, input min_q_out, input max_q_out,
                  input mean_power, output ready);
endinterface

`default_nettype wire

[rtl/iq_capture_statistics_core.sv]
// Statistics over one capture of packed I/Q words.
// Throughput: one sample per cycle within a capture.
// At the last sample of a capture the divider runs CNT_W+19 steps (32 at 4096 samples);
// ready is low while it runs and until the summary is loaded into the output register,
// longer while the previous summary is still waiting to be taken.
// Reset (async, active low): accumulators cleared, capture_length = 4096, no result valid.
`default_nettype none

`include "iq_capture_statistics_core_defines.svh"

module iq_capture_statistics_core #(
  parameter int unsigned MAX_SAMPLES = iqcs_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [iqcs_pkg::CFG_W-1:0] cfg_wdata_i,
  iqcs_samp_if.sink                       samp_i,
  iqcs_summ_if.source                     summ_o
);
  import iqcs_pkg::*;

  iqcs_cmd_t  cmd;
  iqcs_stat_t stat;

  // Sequencer
  iqcs_ctrl #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .samp_valid_i (samp_i.valid),
    .samp_ready_o (samp_i.ready),
    .out_valid_o  (summ_o.valid),
    .out_ready_i  (summ_o.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // Accumulators, dividers, output register
  iqcs_datapath #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .raw_word_i   (samp_i.raw_word),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .mean_i_o     (summ_o.mean_i),
    .mean_q_o     (summ_o.mean_q),
    .min_i_o      (summ_o.min_i_out),
    .max_i_o      (summ_o.max_i_out),
    .min_q_o      (summ_o.min_q_out),
    .max_q_o      (summ_o.max_q_out),
    .mean_power_o (summ_o.mean_power)
  );

  // Checks
  `IQCS_ASSERT_SAME(a_start_on_accept, cmd.start, cmd.accept, "capture closed without a sample")
  `IQCS_ASSERT_NEXT(a_busy_after_start, cmd.start, !samp_i.ready, "sample taken while dividing")
  `IQCS_ASSERT_SAME(a_no_overwrite, cmd.load_out, !summ_o.valid || summ_o.ready,
                    "pending summary overwritten")
  `IQCS_ASSERT_NEXT(a_valid_after_load, cmd.load_out, summ_o.valid, "loaded summary not shown")

endmodule

`default_nettype wire

[rtl/iqcs_datapath.sv]
`default_nettype none

module iqcs_datapath #(
  parameter int unsigned MAX_SAMPLES = iqcs_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [iqcs_pkg::CFG_W-1:0]           cfg_wdata_i,
  input  wire logic [iqcs_pkg::RAW_W-1:0]           raw_word_i,
  input  wire iqcs_pkg::iqcs_cmd_t                  cmd_i,
  output iqcs_pkg::iqcs_stat_t                      stat_o,
  output logic signed [iqcs_pkg::SAMPLE_W-1:0]      mean_i_o,
  output logic signed [iqcs_pkg::SAMPLE_W-1:0]      mean_q_o,
  output logic signed [iqcs_pkg::SAMPLE_W-1:0]      min_i_o,
  output logic signed [iqcs_pkg::SAMPLE_W-1:0]      max_i_o,
  output logic signed [iqcs_pkg::SAMPLE_W-1:0]      min_q_o,
  output logic signed [iqcs_pkg::SAMPLE_W-1:0]      max_q_o,
  output logic [iqcs_pkg::AVG_W-1:0]                mean_power_o
);
  import iqcs_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned SUM_W  = CNT_W + SAMPLE_W;
  localparam int unsigned PWR_W  = CNT_W + 2 * SAMPLE_W - 1;
  localparam int unsigned LEN_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int unsigned NLANES = 3;
  localparam int unsigned LN_I   = 0;
  localparam int unsigned LN_Q   = 1;
  localparam int unsigned LN_P   = 2;

  // Configuration register
  logic [CFG_W-1:0] cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Effective length: zero counts as one, clamp to the depth limit
  logic [LEN_W-1:0] cfg_ext;
  logic [LEN_W-1:0] eff_len;

  always_comb begin
    cfg_ext = LEN_W'(cfg_q);
    if (cfg_ext == '0) begin
      eff_len = LEN_W'(1);
    end else if (cfg_ext > LEN_W'(MAX_SAMPLES)) begin
      eff_len = LEN_W'(MAX_SAMPLES);
    end else begin
      eff_len = cfg_ext;
    end
  end

  // Sample unpack and power
  logic signed [SAMPLE_W-1:0]   smp_i;
  logic signed [SAMPLE_W-1:0]   smp_q;
  logic signed [2*SAMPLE_W-1:0] sqr_i;
  logic signed [2*SAMPLE_W-1:0] sqr_q;
  logic [2*SAMPLE_W-1:0]        pwr_smp;

  assign smp_i   = raw_word_i[2*SAMPLE_W-1:SAMPLE_W];
  assign smp_q   = raw_word_i[SAMPLE_W-1:0];
  assign sqr_i   = smp_i * smp_i;
  assign sqr_q   = smp_q * smp_q;
  assign pwr_smp = unsigned'(sqr_i) + unsigned'(sqr_q);

  // Accumulators
  logic [CNT_W-1:0]           cnt_q;
  logic signed [SUM_W-1:0]    sum_i_q;
  logic signed [SUM_W-1:0]    sum_q_q;
  logic [PWR_W-1:0]           pwr_q;
  logic signed [SAMPLE_W-1:0] min_i_q, max_i_q, min_q_q, max_q_q;

  logic [CNT_W-1:0]           cnt_d;
  logic signed [SUM_W-1:0]    sum_i_d;
  logic signed [SUM_W-1:0]    sum_q_d;
  logic [PWR_W-1:0]           pwr_d;
  logic signed [SAMPLE_W-1:0] min_i_d, max_i_d, min_q_d, max_q_d;

  always_comb begin
    cnt_d   = cnt_q + 1'b1;
    sum_i_d = sum_i_q + SUM_W'(smp_i);
    sum_q_d = sum_q_q + SUM_W'(smp_q);
    pwr_d   = pwr_q + PWR_W'(pwr_smp);
    min_i_d = (smp_i < min_i_q) ? smp_i : min_i_q;
    max_i_d = (smp_i > max_i_q) ? smp_i : max_i_q;
    min_q_d = (smp_q < min_q_q) ? smp_q : min_q_q;
    max_q_d = (smp_q > max_q_q) ? smp_q : max_q_q;
  end

  assign stat_o.cap_done = (LEN_W'(cnt_d) >= eff_len);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      sum_i_q <= '0;
      sum_q_q <= '0;
      pwr_q   <= '0;
      min_i_q <= SAMPLE_MAX;
      max_i_q <= SAMPLE_MIN;
      min_q_q <= SAMPLE_MAX;
      max_q_q <= SAMPLE_MIN;
    end else if (cmd_i.start) begin
      cnt_q   <= '0;
      sum_i_q <= '0;
      sum_q_q <= '0;
      pwr_q   <= '0;
      min_i_q <= SAMPLE_MAX;
      max_i_q <= SAMPLE_MIN;
      min_q_q <= SAMPLE_MAX;
      max_q_q <= SAMPLE_MIN;
    end else if (cmd_i.accept) begin
      cnt_q   <= cnt_d;
      sum_i_q <= sum_i_d;
      sum_q_q <= sum_q_d;
      pwr_q   <= pwr_d;
      min_i_q <= min_i_d;
      max_i_q <= max_i_d;
      min_q_q <= min_q_d;
      max_q_q <= max_q_d;
    end
  end

  // Divider operands: magnitudes of the final sums
  logic [SUM_W-1:0] mag_i;
  logic [SUM_W-1:0] mag_q;

  assign mag_i = sum_i_d[SUM_W-1] ? unsigned'(-sum_i_d) : unsigned'(sum_i_d);
  assign mag_q = sum_q_d[SUM_W-1] ? unsigned'(-sum_q_d) : unsigned'(sum_q_d);

  // Restoring divider lanes, one quotient bit per step, shared divisor
  logic [PWR_W-1:0]           quo_q [NLANES];
  logic [CNT_W-1:0]           rem_q [NLANES];
  logic [PWR_W-1:0]           quo_d [NLANES];
  logic [CNT_W-1:0]           rem_d [NLANES];
  logic [CNT_W-1:0]           den_q;
  logic                       neg_i_q, neg_q_q;
  logic signed [SAMPLE_W-1:0] hmin_i_q, hmax_i_q, hmin_q_q, hmax_q_q;

  for (genvar k = 0; k < NLANES; k++) begin : g_lane
    logic [CNT_W:0] shl;
    logic           ge;

    always_comb begin
      shl      = {rem_q[k], quo_q[k][PWR_W-1]};
      ge       = (shl >= {1'b0, den_q});
      rem_d[k] = ge ? CNT_W'(shl - {1'b0, den_q}) : CNT_W'(shl);
      quo_d[k] = {quo_q[k][PWR_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      quo_q[LN_I] <= PWR_W'(mag_i);
      quo_q[LN_Q] <= PWR_W'(mag_q);
      quo_q[LN_P] <= pwr_d;
      for (int k = 0; k < NLANES; k++) begin
        rem_q[k] <= '0;
      end
      den_q    <= cnt_d;
      neg_i_q  <= sum_i_d[SUM_W-1];
      neg_q_q  <= sum_q_d[SUM_W-1];
      hmin_i_q <= min_i_d;
      hmax_i_q <= max_i_d;
      hmin_q_q <= min_q_d;
      hmax_q_q <= max_q_d;
    end else if (cmd_i.step) begin
      for (int k = 0; k < NLANES; k++) begin
        quo_q[k] <= quo_d[k];
        rem_q[k] <= rem_d[k];
      end
    end
  end

  // Output register, restores the sign of the means
  logic [SAMPLE_W-1:0] qi_lo;
  logic [SAMPLE_W-1:0] qq_lo;

  assign qi_lo = quo_q[LN_I][SAMPLE_W-1:0];
  assign qq_lo = quo_q[LN_Q][SAMPLE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mean_i_o     <= neg_i_q ? signed'(-qi_lo) : signed'(qi_lo);
      mean_q_o     <= neg_q_q ? signed'(-qq_lo) : signed'(qq_lo);
      min_i_o      <= hmin_i_q;
      max_i_o      <= hmax_i_q;
      min_q_o      <= hmin_q_q;
      max_q_o      <= hmax_q_q;
      mean_power_o <= quo_q[LN_P][AVG_W-1:0];
    end
  end

endmodule

`default_nettype wire

[rtl/iqcs_ctrl.sv]
`default_nettype none

module iqcs_ctrl #(
  parameter int unsigned MAX_SAMPLES = iqcs_pkg::MAX_SAMPLES_DEF
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 samp_valid_i,
  output logic                      samp_ready_o,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  input  wire iqcs_pkg::iqcs_stat_t stat_i,
  output iqcs_pkg::iqcs_cmd_t       cmd_o
);
  import iqcs_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned PWR_W  = CNT_W + 2 * SAMPLE_W - 1;
  localparam int unsigned ITER_W = $clog2(PWR_W);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_DIV  = 3'b010,
    ST_HOLD = 3'b100
  } iqcs_state_e;

  iqcs_state_e       state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    iter_d       = iter_q;
    cmd_o        = '0;
    samp_ready_o = 1'b0;
    case (state_q)
      ST_RUN: begin
        samp_ready_o = 1'b1;
        cmd_o.accept = samp_valid_i;
        if (samp_valid_i && stat_i.cap_done) begin
          cmd_o.start = 1'b1;
          iter_d      = ITER_W'(PWR_W - 1);
          state_d     = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.step = 1'b1;
        if (iter_q == '0) begin
          state_d = ST_HOLD;
        end else begin
          iter_d = iter_q - 1'b1;
        end
      end
      ST_HOLD: begin
        // wait for the output register to free up
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  // Result valid flag
  always_comb begin
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

[dv/iq_capture_statistics_core_tb.sv]
`timescale 1ns / 100ps

module iq_capture_statistics_core_tb;
  import iqcs_pkg::*;

  localparam int unsigned CAP_MAX         = MAX_SAMPLES_DEF;
  localparam int unsigned DRAIN_CYCLES    = 64;   // divider run plus output register
  localparam int unsigned CYCLE_LIMIT     = 2_000_000;
  localparam int unsigned RANDOM_SAMPLES  = 500;
  localparam int unsigned PARTIAL_SAMPLES = 150;  // long capture left open, then closed

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_i;
    logic signed [SAMPLE_W-1:0] mean_q;
    logic signed [SAMPLE_W-1:0] min_i;
    logic signed [SAMPLE_W-1:0] max_i;
    logic signed [SAMPLE_W-1:0] min_q;
    logic signed [SAMPLE_W-1:0] max_q;
    logic [AVG_W-1:0]           mean_power;
  } summary_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  iqcs_samp_if samp_bus ();
  iqcs_summ_if summ_bus ();

  iq_capture_statistics_core #(
    .MAX_SAMPLES (CAP_MAX)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .samp_i      (samp_bus),
    .summ_o      (summ_bus)
  );

  // Capture statistics predictor state
  logic [CFG_W-1:0] cap_len_model;
  int               cap_count;
  longint           sum_i_est;
  longint           sum_q_est;
  longint           power_est;
  int               lo_i, hi_i, lo_q, hi_q;

  summary_t pending_summaries[$];
  int       mismatch_count;
  int       cycle_count;
  bit       calm;   // no idling on either side while set

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("iq_capture_statistics_core_tb NOT OK");
    $finish;
  end

  // Idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // One sample component, biased toward the extremes
  function automatic logic [SAMPLE_W-1:0] pick_component();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return SAMPLE_MIN;
    if (r < 20) return SAMPLE_MAX;
    if (r < 25) return '0;
    if (r < 30) return '1;
    return SAMPLE_W'($urandom());
  endfunction

  function automatic logic [RAW_W-1:0] random_word();
    return {pick_component(), pick_component()};
  endfunction

  function automatic void clear_capture_model();
    cap_count = 0;
    sum_i_est = 0;
    sum_q_est = 0;
    power_est = 0;
    lo_i      = 511;
    hi_i      = -512;
    lo_q      = 511;
    hi_q      = -512;
  endfunction

  // Fold one accepted sample in; queue a summary when the capture closes
  function automatic void accumulate_sample(input logic [RAW_W-1:0] word);
    int       si, sq, target;
    summary_t s;
    si = $signed(word[RAW_W-1:SAMPLE_W]);
    sq = $signed(word[SAMPLE_W-1:0]);
    sum_i_est += si;
    sum_q_est += sq;
    power_est += si * si + sq * sq;
    if (si < lo_i) lo_i = si;
    if (si > hi_i) hi_i = si;
    if (sq < lo_q) lo_q = sq;
    if (sq > hi_q) hi_q = sq;
    cap_count++;
    // zero length acts as one, oversize lengths clamp to the depth limit
    if (cap_len_model == 0) target = 1;
    else if (cap_len_model > CAP_MAX) target = CAP_MAX;
    else target = int'(cap_len_model);
    if (cap_count < target) return;
    s.mean_i     = SAMPLE_W'(sum_i_est / cap_count);
    s.mean_q     = SAMPLE_W'(sum_q_est / cap_count);
    s.min_i      = SAMPLE_W'(lo_i);
    s.max_i      = SAMPLE_W'(hi_i);
    s.min_q      = SAMPLE_W'(lo_q);
    s.max_q      = SAMPLE_W'(hi_q);
    s.mean_power = AVG_W'(power_est / cap_count);
    pending_summaries.push_back(s);
    clear_capture_model();
  endfunction

  // Summary side backpressure
  initial begin : summ_stall
    int gap;
    summ_bus.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        summ_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      summ_bus.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Compare each summary request against the oldest prediction
  always @(posedge clk_i) begin : check_summary
    summary_t want;
    if (rst_ni && summ_bus.valid && summ_bus.ready) begin
      if (pending_summaries.size() == 0) begin
        mismatch_count++;
        $display("%0t: summary expected none, got mean_i %0d mean_q %0d mean_power %0d",
                 $time, summ_bus.mean_i, summ_bus.mean_q, summ_bus.mean_power);
      end else begin
        want = pending_summaries.pop_front();
        check_field("mean_i", want.mean_i, summ_bus.mean_i);
        check_field("mean_q", want.mean_q, summ_bus.mean_q);
        check_field("min_i_out", want.min_i, summ_bus.min_i_out);
        check_field("max_i_out", want.max_i, summ_bus.max_i_out);
        check_field("min_q_out", want.min_q, summ_bus.min_q_out);
        check_field("max_q_out", want.max_q, summ_bus.max_q_out);
        check_field("mean_power", want.mean_power, summ_bus.mean_power);
      end
    end
  end

  // Issue one sample request; entered and left just after a falling edge
  task automatic send_sample(input logic [RAW_W-1:0] word);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      samp_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    samp_bus.valid    <= 1'b1;
    samp_bus.raw_word <= word;
    @(posedge clk_i);
    while (!samp_bus.ready) @(posedge clk_i);
    accumulate_sample(word);
    @(negedge clk_i);
  endtask

  // Stop sending, collect every summary, let the divider go quiet
  task automatic settle();
    samp_bus.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_summaries.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_length(input logic [CFG_W-1:0] len);
    cfg_we        <= 1'b1;
    cfg_wdata     <= len;
    cap_len_model  = len;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  // Reset length keeps a long capture open; a length of one then closes it
  task automatic test_reset_length();
    repeat (PARTIAL_SAMPLES) send_sample(random_word());
    settle();
    write_length(CFG_W'(1));
    send_sample(random_word());
  endtask

  // Component extremes and truncation toward zero of negative means
  task automatic test_extremes();
    settle();
    write_length(CFG_W'(4));
    repeat (4) send_sample({SAMPLE_MIN, SAMPLE_MIN});
    repeat (4) send_sample({SAMPLE_MAX, SAMPLE_MAX});
    send_sample({SAMPLE_MIN, SAMPLE_MAX});
    send_sample({SAMPLE_MAX, SAMPLE_MIN});
    send_sample({SAMPLE_W'(0), SAMPLE_W'(0)});
    send_sample({SAMPLE_W'(-1), SAMPLE_W'(-1)});
  endtask

  // Length zero behaves as one: a summary per sample
  task automatic test_length_zero();
    settle();
    write_length('0);
    repeat (3) send_sample(random_word());
    settle();
    write_length(CFG_W'(1));
    repeat (2) send_sample(random_word());
  endtask

  // Shrinking the length below the running count closes on the next sample
  task automatic test_length_change();
    settle();
    write_length(CFG_W'(10));
    repeat (6) send_sample(random_word());
    settle();
    write_length(CFG_W'(4));
    send_sample(random_word());
  endtask

  // Oversize length keeps the capture open like a long one
  task automatic test_length_clamp();
    settle();
    write_length('1);
    repeat (PARTIAL_SAMPLES) send_sample(random_word());
    settle();
    write_length(CFG_W'(1));
    send_sample(random_word());
  endtask

  // Random lengths, mostly whole captures, some left partial
  task automatic test_random();
    int sent, r, len, eff, n;
    sent = 0;
    while (sent < RANDOM_SAMPLES) begin
      r = $urandom_range(0, 99);
      if (r < 10) len = 0;
      else if (r < 15) len = 1;
      else if (r < 80) len = $urandom_range(2, 16);
      else if (r < 95) len = $urandom_range(17, 64);
      else len = $urandom_range(65, 200);
      settle();
      write_length(CFG_W'(len));
      calm = ($urandom_range(0, 3) == 0);
      eff  = (len == 0) ? 1 : len;
      n    = eff * ((eff > 64) ? 1 : $urandom_range(1, 3));
      if ($urandom_range(0, 3) == 0) n -= $urandom_range(0, eff - 1);
      repeat (n) send_sample(random_word());
      sent += n;
    end
    calm = 1'b0;
  endtask

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    samp_bus.valid    = 1'b0;
    samp_bus.raw_word = '0;
    calm              = 1'b0;
    mismatch_count    = 0;
    cap_len_model     = CFG_RESET;
    clear_capture_model();
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_reset_length();
    test_extremes();
    test_length_zero();
    test_length_change();
    test_length_clamp();
    test_random();
    settle();

    if (mismatch_count == 0) begin
      $display("iq_capture_statistics_core_tb OK");
    end else begin
      $display("iq_capture_statistics_core_tb NOT OK");
    end
    $finish;
  end

endmodule
